>>> hdl/line_sensor_centroid_defines.svh
// Assertion macros for the line sensor centroid block.
// Used by line_sensor_centroid.sv; expects clk and rst_n in scope.
`ifndef LINE_SENSOR_CENTROID_DEFINES_SVH
`define LINE_SENSOR_CENTROID_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_sensor_centroid: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define LSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_sensor_centroid: next-cycle check failed");

`endif

>>> hdl/lsc_pkg.sv
// Shared constants, types and helpers for the line sensor centroid block.
// No dependencies; used by lsc_ctrl, lsc_datapath and line_sensor_centroid.
`default_nettype none

package lsc_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int READING_BITS = 12;

    // result field widths
    localparam int POS_BITS = 11;
    localparam int CNT_BITS = 4;

    localparam int OPCODE_BITS = 2;
    localparam logic [OPCODE_BITS-1:0] OP_MEASURE   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_CAL_WHITE = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_CAL_BLACK = 2'd2;

    // one half sensor spacing in 1/256 units
    localparam int HALF_STEP = 128;
    localparam int HALF_SHIFT = $clog2(HALF_STEP);

    localparam logic [READING_BITS-1:0] WHITE_DEFAULT = READING_BITS'(4000);
    localparam logic [READING_BITS-1:0] BLACK_DEFAULT = READING_BITS'(3850);
    localparam logic [READING_BITS:0] LEVEL_SUM_DEFAULT =
        {1'b0, WHITE_DEFAULT} + {1'b0, BLACK_DEFAULT};
    localparam logic [READING_BITS-1:0] THR_DEFAULT = LEVEL_SUM_DEFAULT[READING_BITS:1];

    // active count 0..SENSOR_COUNT
    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    // largest magnitude of the weight sum, in half spacings
    localparam int MAX_ABS_HALVES = SENSOR_COUNT * SENSOR_COUNT / 4;
    localparam int SUMH_W = $clog2(MAX_ABS_HALVES + 1) + 1;
    localparam int ABSH_W = SUMH_W - 1;
    localparam int DIVD_W = $clog2(MAX_ABS_HALVES * HALF_STEP + 1);

    // divider: quotient bits resolved per cycle and number of cycles
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYCLES = (DIVD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUO_W = DIV_CYCLES * DIV_STEPS;
    localparam int REM_W = CNT_W + 1;
    localparam int ITER_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // bound of the reported position, 1/256 units
    localparam int POS_LIMIT = (SENSOR_COUNT - 1) * HALF_STEP;

    // stream packing
    localparam int IN_FIELD_BITS = OPCODE_BITS + SENSOR_COUNT * READING_BITS;
    localparam int IN_DATA_W = (IN_FIELD_BITS + 7) / 8 * 8;
    localparam int OUT_FIELD_BITS = POS_BITS + CNT_BITS;
    localparam int OUT_DATA_W = (OUT_FIELD_BITS + 7) / 8 * 8;

    typedef logic [READING_BITS-1:0] reading_t;
    typedef reading_t [SENSOR_COUNT-1:0] scan_t;

    typedef struct packed {
        logic accept;    // take a request from the input port
        logic prep;      // reduce the mask to count and dividend
        logic div_step;  // resolve DIV_STEPS quotient bits
        logic out_load;  // move the finished result to the output register
    } lsc_cmd_t;

    // centered weight of sensor idx in half spacings: 2*idx - (N-1)
    function automatic logic signed [SUMH_W-1:0] sensor_weight(input int idx);
        return SUMH_W'(2 * idx - (SENSOR_COUNT - 1));
    endfunction

endpackage

`default_nettype wire

>>> hdl/lsc_ctrl.sv
// Sequencer for the line sensor centroid block: handshakes and step commands.
// Depends on lsc_pkg.
`default_nettype none

module lsc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output lsc_pkg::lsc_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [lsc_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == lsc_pkg::ITER_W'(lsc_pkg::DIV_CYCLES - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lsc_datapath.sv
// Datapath for the line sensor centroid block: calibration levels, thresholds,
// sensor mask, signed centroid divider and output register. Depends on lsc_pkg.
`default_nettype none

module lsc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lsc_pkg::lsc_cmd_t                   cmd,
    input  wire logic [lsc_pkg::OPCODE_BITS-1:0]     opcode,
    input  wire lsc_pkg::scan_t                      readings,
    output logic signed [lsc_pkg::POS_BITS-1:0]      line_position,
    output logic [lsc_pkg::CNT_BITS-1:0]             active_count
);

    lsc_pkg::scan_t white_reg, black_reg, thr_reg;
    logic [lsc_pkg::SENSOR_COUNT-1:0] mask_reg;
    logic [lsc_pkg::CNT_W-1:0] cnt_reg;
    logic neg_reg;
    logic [lsc_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [lsc_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [lsc_pkg::POS_BITS-1:0] pos_reg;
    logic [lsc_pkg::CNT_BITS-1:0] acnt_reg;

    logic [lsc_pkg::CNT_W-1:0] cnt_sum;
    logic signed [lsc_pkg::SUMH_W-1:0] halves_sum;
    logic [lsc_pkg::ABSH_W-1:0] halves_abs;
    logic [lsc_pkg::POS_BITS-1:0] pos_mag;

    // calibration: levels and thresholds, all reset to the default levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
            begin
                white_reg[i] <= lsc_pkg::WHITE_DEFAULT;
                black_reg[i] <= lsc_pkg::BLACK_DEFAULT;
                thr_reg[i]   <= lsc_pkg::THR_DEFAULT;
            end
        end
        else if (cmd.accept)
        begin
            for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
            begin
                if (opcode == lsc_pkg::OP_CAL_WHITE)
                begin
                    white_reg[i] <= readings[i];
                    thr_reg[i]   <= lsc_pkg::READING_BITS'(
                        ({1'b0, readings[i]} + {1'b0, black_reg[i]}) >> 1);
                end
                else if (opcode == lsc_pkg::OP_CAL_BLACK)
                begin
                    black_reg[i] <= readings[i];
                    thr_reg[i]   <= lsc_pkg::READING_BITS'(
                        ({1'b0, white_reg[i]} + {1'b0, readings[i]}) >> 1);
                end
            end
        end
    end

    // reduce the mask: count and signed weight sum
    always_comb
    begin
        cnt_sum    = '0;
        halves_sum = '0;
        for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
        begin
            if (mask_reg[i])
            begin
                cnt_sum    = cnt_sum + 1'b1;
                halves_sum = halves_sum + lsc_pkg::sensor_weight(i);
            end
        end
        halves_abs = halves_sum[lsc_pkg::SUMH_W-1]
                   ? lsc_pkg::ABSH_W'(-halves_sum)
                   : lsc_pkg::ABSH_W'(halves_sum);
    end

    // restoring division, DIV_STEPS quotient bits per cycle
    always_comb
    begin
        logic [lsc_pkg::REM_W-1:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < lsc_pkg::DIV_STEPS; k++)
        begin
            trial    = {rem_next[lsc_pkg::REM_W-2:0], quo_next[lsc_pkg::QUO_W-1]};
            quo_next = {quo_next[lsc_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, cnt_reg})
            begin
                rem_next    = trial - {1'b0, cnt_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            // only a measure request marks sensors
            for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
            begin
                mask_reg[i] <= (opcode == lsc_pkg::OP_MEASURE) && (readings[i] < thr_reg[i]);
            end
        end
        if (cmd.prep)
        begin
            cnt_reg <= cnt_sum;
            neg_reg <= halves_sum[lsc_pkg::SUMH_W-1];
            quo_reg <= lsc_pkg::QUO_W'(halves_abs) << lsc_pkg::HALF_SHIFT;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            pos_reg  <= (cnt_reg == '0) ? '0 : (neg_reg ? -pos_mag : pos_mag);
            acnt_reg <= lsc_pkg::CNT_BITS'(cnt_reg);
        end
    end

    assign pos_mag       = lsc_pkg::POS_BITS'(quo_reg);
    assign line_position = pos_reg;
    assign active_count  = acnt_reg;

endmodule

`default_nettype wire

>>> hdl/line_sensor_centroid.sv
// Line sensor centroid: top level joining the sequencer and the datapath.
// Depends on lsc_pkg, lsc_ctrl, lsc_datapath and line_sensor_centroid_defines.svh.
//
// Usage:
//   Slave channel (s_*) takes one request per scan: an opcode and eight
//   12-bit readings. Opcode measure marks each sensor below its threshold
//   and reports the centroid of the marked sensors' centered weights in
//   1/256 sensor spacing (truncated toward zero) plus the marked count.
//   Calibrate white/black stores the scan as that level and recomputes every
//   threshold as the floor of the white and black mean; it reports zeros,
//   as does the unused opcode, which leaves the state alone.
//   Master channel (m_*) returns one result per request, in order.
// Sequence:
//   After acceptance a request is worked through in order: the mask is
//   reduced to a count and dividend, the 4-bit-per-cycle divider resolves
//   the quotient, and the result is loaded into the output register. The
//   next request is taken only after that load; s_tready is high only
//   while the sequencer is idle.
// Reset:
//   rst_n clears the handshakes and loads white 4000, black 3850, threshold
//   3925 into every sensor slot.
// Stall:
//   A result waiting on m_tready stays put; the next request may still be
//   accepted and worked on, and its result holds until the register frees.
`default_nettype none
`include "line_sensor_centroid_defines.svh"

module line_sensor_centroid (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // opcode[1:0], reading_0 .. reading_7 (12 bits each), zero fill
    input  wire logic [lsc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // line_position[10:0] (signed), active_count[14:11], zero fill
    output logic [lsc_pkg::OUT_DATA_W-1:0]        m_tdata
);

    lsc_pkg::lsc_cmd_t cmd;
    lsc_pkg::scan_t readings;
    logic [lsc_pkg::OPCODE_BITS-1:0] opcode;
    logic signed [lsc_pkg::POS_BITS-1:0] line_position;
    logic [lsc_pkg::CNT_BITS-1:0] active_count;

    // unpack the scan from the request word
    assign opcode = s_tdata[lsc_pkg::OPCODE_BITS-1:0];
    always_comb
    begin
        for (int i = 0; i < lsc_pkg::SENSOR_COUNT; i++)
        begin
            readings[i] = s_tdata[lsc_pkg::OPCODE_BITS + i * lsc_pkg::READING_BITS
                                  +: lsc_pkg::READING_BITS];
        end
    end

    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lsc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (opcode),
        .readings      (readings),
        .line_position (line_position),
        .active_count  (active_count)
    );

    // pack the result, zero fill to whole bytes
    assign m_tdata = lsc_pkg::OUT_DATA_W'({active_count, line_position});

    // the sequencer stops taking requests right after one is accepted
    `LSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // an empty scan always reports the center
    `LSC_ASSERT_NOW(a_empty_center, m_tvalid && (active_count == '0), line_position == '0)
    // the position stays within the outermost sensors
    `LSC_ASSERT_NOW(a_pos_range, m_tvalid,
        (line_position <= lsc_pkg::POS_BITS'(lsc_pkg::POS_LIMIT)) &&
        (line_position >= -lsc_pkg::POS_BITS'(lsc_pkg::POS_LIMIT)))
    // the count never exceeds the number of sensors
    `LSC_ASSERT_NOW(a_cnt_range, m_tvalid,
        active_count <= lsc_pkg::CNT_BITS'(lsc_pkg::SENSOR_COUNT))

endmodule

`default_nettype wire

>>> sim/tb_line_sensor_centroid.sv
`timescale 1ns / 1ps
// Testbench for line_sensor_centroid: directed scan rows, then random scans.
// Depends on lsc_pkg and the line_sensor_centroid RTL; checks each result
// against its typed value or a local predictor.

module tb_line_sensor_centroid;
    import lsc_pkg::*;

    // the opcode that has no meaning: state untouched, zero result
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_SCANS = 1780;
    // long output hold-off, started once this many requests went in
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    // window of requests during which neither side idles
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1200;
    // longest legal stretch without a handshake is the hold-off above
    localparam int STALL_LIMIT = 3000;
    // extra wait at the end, after the last expected result came back
    localparam int DRAIN_CYCLES = 20;
    localparam reading_t READ_MAX = '1;

    typedef struct packed {
        logic signed [POS_BITS-1:0] line_position;
        logic [CNT_BITS-1:0]        active_count;
    } centroid_t;

    typedef struct {
        logic [OPCODE_BITS-1:0] opcode;
        scan_t                  scan;
        bit                     known;   // result typed in below
        centroid_t              result;
    } scan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // opcode[1:0], reading_0 .. reading_7 (12 bits each), zero fill
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // line_position[10:0] (signed), active_count[14:11], zero fill
    logic [OUT_DATA_W-1:0] m_tdata;

    // predictor state: per-sensor calibration levels and thresholds
    reading_t white_lvl [SENSOR_COUNT];
    reading_t black_lvl [SENSOR_COUNT];
    reading_t thr_lvl   [SENSOR_COUNT];

    centroid_t centroid_q [$];   // expected results, oldest first
    scan_row_t scan_rows [$];    // directed stimulus
    int        scans_sent;
    int        mismatches;
    int        idle_cycles;

    line_sensor_centroid uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit quiet_window();
        return scans_sent >= QUIET_FROM && scans_sent < QUIET_TO;
    endfunction

    function automatic reading_t clamp_reading(input int v);
        if (v < 0)
            return '0;
        if (v > int'(READ_MAX))
            return READ_MAX;
        return reading_t'(v);
    endfunction

    function automatic scan_t flat_scan(input reading_t v);
        scan_t s;
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = v;
        return s;
    endfunction

    // Advance the calibration state and work out the result of one request.
    function automatic centroid_t predict_centroid(input logic [OPCODE_BITS-1:0] opcode,
                                                   input scan_t scan);
        centroid_t res;
        int        weight_sum;
        int        marked;
        weight_sum = 0;
        marked = 0;
        if (opcode == OP_MEASURE)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
                if (scan[i] < thr_lvl[i])
                begin
                    // centered weight in half spacings, one half is HALF_STEP
                    weight_sum += (2 * i - (SENSOR_COUNT - 1)) * HALF_STEP;
                    marked++;
                end
        end
        else if (opcode == OP_CAL_WHITE || opcode == OP_CAL_BLACK)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                if (opcode == OP_CAL_WHITE)
                    white_lvl[i] = scan[i];
                else
                    black_lvl[i] = scan[i];
                thr_lvl[i] = reading_t'(({1'b0, white_lvl[i]} + {1'b0, black_lvl[i]}) >> 1);
            end
        end
        // SV division truncates toward zero
        res.line_position = POS_BITS'((marked > 0) ? weight_sum / marked : 0);
        res.active_count = CNT_BITS'(marked);
        return res;
    endfunction

    task automatic add_row(input logic [OPCODE_BITS-1:0] opcode, input scan_t scan,
                           input bit known, input int pos, input int cnt);
        scan_row_t row;
        row.opcode = opcode;
        row.scan = scan;
        row.known = known;
        row.result.line_position = POS_BITS'(pos);
        row.result.active_count = CNT_BITS'(cnt);
        scan_rows.push_back(row);
    endtask

    // Draw one random request. Most are measures shaped like a line under the
    // array, readings a small or wide margin across the current thresholds;
    // the rest are calibrations, unused opcodes and full-range noise.
    task automatic draw_scan(output logic [OPCODE_BITS-1:0] opcode, output scan_t scan);
        int pick;
        int center;
        int half_width;
        int margin;
        pick = $urandom_range(99);
        center = $urandom_range(SENSOR_COUNT - 1);
        half_width = $urandom_range(3);
        margin = ($urandom_range(1)) ? 4 : 600;
        opcode = OP_MEASURE;
        if (pick < 5)
            opcode = OP_CAL_WHITE;
        else if (pick < 10)
            opcode = OP_CAL_BLACK;
        else if (pick < 13)
            opcode = OP_UNUSED;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (opcode == OP_CAL_WHITE && pick < 4)
                scan[i] = reading_t'($urandom_range(4095, 2500));
            else if (opcode == OP_CAL_BLACK && pick < 9)
                scan[i] = reading_t'($urandom_range(1500, 0));
            else if (opcode != OP_MEASURE || pick >= 80)
                scan[i] = reading_t'($urandom_range(int'(READ_MAX)));
            else if (i >= center - half_width && i <= center + half_width)
                scan[i] = clamp_reading(int'(thr_lvl[i]) - $urandom_range(margin, 1));
            else
                scan[i] = clamp_reading(int'(thr_lvl[i]) + $urandom_range(margin - 1, 0));
        end
    endtask

    // Offer one request; idle now and then before it, hold it until taken,
    // then queue what it should produce.
    task automatic offer_scan(input logic [OPCODE_BITS-1:0] opcode, input scan_t scan,
                              input bit known, input centroid_t typed);
        centroid_t predicted;
        @(negedge clk);
        while (!quiet_window() && $urandom_range(99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_DATA_W'({scan, opcode});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_centroid(opcode, scan);
        centroid_q.push_back(known ? typed : predicted);
        scans_sent++;
    endtask

    // Sender: reset, directed rows, random requests, then drain and report.
    initial
    begin
        scan_t                  s;
        logic [OPCODE_BITS-1:0] op;
        centroid_t              none;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        scans_sent = 0;
        mismatches = 0;
        none = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            white_lvl[i] = WHITE_DEFAULT;
            black_lvl[i] = BLACK_DEFAULT;
            thr_lvl[i] = reading_t'(({1'b0, WHITE_DEFAULT} + {1'b0, BLACK_DEFAULT}) >> 1);
        end

        // Directed rows; thresholds start at 3925 out of reset.
        add_row(OP_MEASURE, flat_scan(READ_MAX), 1, 0, 0);        // nothing marked
        add_row(OP_MEASURE, flat_scan('0), 1, 0, 8);              // all marked, centered
        s = flat_scan(READ_MAX);
        s[0] = '0;
        add_row(OP_MEASURE, s, 1, -896, 1);                       // leftmost alone
        s = flat_scan(READ_MAX);
        s[SENSOR_COUNT - 1] = '0;
        add_row(OP_MEASURE, s, 1, 896, 1);                        // rightmost alone
        add_row(OP_MEASURE, flat_scan(reading_t'(3924)), 1, 0, 8); // one below threshold
        add_row(OP_MEASURE, flat_scan(reading_t'(3925)), 1, 0, 0); // equal is not marked
        s = flat_scan(reading_t'(3925));
        s[0] = reading_t'(3924);
        s[1] = reading_t'(3924);
        s[7] = reading_t'(3924);
        add_row(OP_MEASURE, s, 0, 0, 0);                          // quotient truncates
        add_row(OP_UNUSED, flat_scan('0), 1, 0, 0);               // must leave state alone
        add_row(OP_MEASURE, flat_scan(reading_t'(3924)), 0, 0, 0);
        add_row(OP_CAL_WHITE, flat_scan(READ_MAX), 1, 0, 0);
        add_row(OP_CAL_BLACK, flat_scan('0), 1, 0, 0);            // thresholds now 2047
        add_row(OP_MEASURE, flat_scan(reading_t'(2046)), 1, 0, 8);
        add_row(OP_MEASURE, flat_scan(reading_t'(2047)), 1, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = (i % 2 == 0) ? '0 : READ_MAX;
        add_row(OP_MEASURE, s, 0, 0, 0);
        add_row(OP_CAL_BLACK, flat_scan(READ_MAX), 1, 0, 0);      // thresholds at full scale
        add_row(OP_MEASURE, flat_scan(READ_MAX), 1, 0, 0);
        add_row(OP_MEASURE, flat_scan(reading_t'(4094)), 1, 0, 8);
        add_row(OP_CAL_WHITE, flat_scan('0), 1, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = reading_t'(3000 + 100 * i);
        add_row(OP_CAL_WHITE, s, 1, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = reading_t'(500 + 37 * i);
        add_row(OP_CAL_BLACK, s, 1, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = reading_t'(1700 + 80 * i + ((i % 3 == 0) ? 200 : -200));
        add_row(OP_MEASURE, s, 0, 0, 0);
        for (int i = 0; i < SENSOR_COUNT; i++)
            s[i] = reading_t'((i < 3) ? 0 : 4095 - i);
        add_row(OP_MEASURE, s, 0, 0, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (scan_rows[k])
            offer_scan(scan_rows[k].opcode, scan_rows[k].scan, scan_rows[k].known,
                       scan_rows[k].result);

        for (int n = 0; n < RANDOM_SCANS; n++)
        begin
            draw_scan(op, s);
            offer_scan(op, s, 0, none);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS line_sensor_centroid");
        else
            $display("FAIL line_sensor_centroid");
        $finish;
    end

    // Receiver: random stalls, one long hold-off so the block backs up into
    // its input, and no stalls at all inside the quiet window.
    initial
    begin
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && scans_sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= quiet_window() || $urandom_range(99) >= 8;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        centroid_t want;
        centroid_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.line_position = m_tdata[POS_BITS-1:0];
            got.active_count = m_tdata[POS_BITS +: CNT_BITS];
            if (centroid_q.size() == 0)
            begin
                $error("result: none expected, got line_position %0d active_count %0d",
                       got.line_position, got.active_count);
                mismatches++;
            end
            else
            begin
                want = centroid_q.pop_front();
                if (got.line_position !== want.line_position)
                begin
                    $error("line_position: expected %0d, actual %0d",
                           want.line_position, got.line_position);
                    mismatches++;
                end
                if (got.active_count !== want.active_count)
                begin
                    $error("active_count: expected %0d, actual %0d",
                           want.active_count, got.active_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no handshake happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL line_sensor_centroid");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> line_sensor_centroid.f
+incdir+hdl
hdl/lsc_pkg.sv
hdl/lsc_ctrl.sv
hdl/lsc_datapath.sv
hdl/line_sensor_centroid.sv
sim/tb_line_sensor_centroid.sv
